// ===== hw/rtl/median_kappa_sigma_stacker_top_macros.svh =====
// Assertion macros for the stacker RTL.
// Needs clk and rst_n in the module that uses them.
`ifndef MEDIAN_KAPPA_SIGMA_STACKER_TOP_MACROS_SVH
`define MEDIAN_KAPPA_SIGMA_STACKER_TOP_MACROS_SVH
`ifndef SYNTH
`define MKSS_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define MKSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MKSS_ASSERT(lbl, expr)
`define MKSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/mkss_pkg.sv =====
// Shared constants and types for the median kappa-sigma stacker.
// No dependencies.
package mkss_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA_Q     = 4'd1;

    localparam logic [6:0]  FRAME_COUNT_RST = 7'd2;
    localparam logic [11:0] KAPPA_Q_RST     = 12'd512;

    localparam int KAPPA_W = 12;
    localparam int FRAC    = 16;   // 65536 scale on the deviation side

    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QPW    = $clog2(QDEPTH);

    typedef struct packed {
        logic           empty;
        logic [QCW-1:0] used;
    } q_status_t;

endpackage

// ===== hw/rtl/mkss_desc_q.sv =====
// Short queue of finished-pixel descriptors between front and back.
// Depends on mkss_pkg.
module mkss_desc_q #(
    parameter int WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic                rd_en,
    output logic [WIDTH-1:0]    rd_data,
    output mkss_pkg::q_status_t status
);
    import mkss_pkg::*;

    logic [WIDTH-1:0] slot_reg [QDEPTH];
    logic [QPW-1:0]   wp_reg, rp_reg;
    logic [QCW-1:0]   used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == QPW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == QPW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            used_reg <= used_reg + QCW'(wr_en) - QCW'(rd_en);
        end
    end

    assign rd_data      = slot_reg[rp_reg];
    assign status.empty = (used_reg == '0);
    assign status.used  = used_reg;

endmodule

// ===== hw/rtl/mkss_front.sv =====
// Front end: takes samples, writes them to the sample store, keeps running sums
// and queues a descriptor per finished pixel. Depends on mkss_pkg.
module mkss_front #(
    parameter int MAX_FRAMES  = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int CW     = $clog2(MAX_FRAMES + 1),
    localparam int IW     = $clog2(MAX_FRAMES),
    localparam int AW     = IW + 1,
    localparam int TW     = SAMPLE_BITS + CW,
    localparam int QW     = 2 * SAMPLE_BITS + CW,
    localparam int DESC_W = 2 + CW + TW + QW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [SAMPLE_BITS-1:0] sample_v,
    input  logic                   last_of_image,
    input  logic [CW-1:0]          n_eff,
    input  mkss_pkg::q_status_t    q_status,
    input  logic                   back_busy,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [SAMPLE_BITS-1:0] mem_wdata,
    output logic                   desc_push,
    output logic [DESC_W-1:0]      desc_data
);
    import mkss_pkg::*;

    logic [CW-1:0] held_reg, held_next;
    logic [TW-1:0] total_reg, total_next;
    logic [QW-1:0] sq_reg, sq_next;
    logic          pend_reg, pend_next;
    logic          bank_reg, bank_next;

    logic          accept, complete;
    logic [CW-1:0] held_inc;
    logic [TW-1:0] total_add;
    logic [QW-1:0] sq_add;
    logic [QCW:0]  outstanding;

    // each pixel in the queue or in the back end holds a bank
    assign outstanding = {1'b0, q_status.used} + (QCW + 1)'(back_busy);
    assign full        = (outstanding >= (QCW + 1)'(2));
    assign accept      = push && !full;

    assign held_inc  = held_reg + 1'b1;
    assign total_add = total_reg + TW'(sample_v);
    assign sq_add    = sq_reg + QW'(sample_v) * QW'(sample_v);
    assign complete  = accept && (held_inc >= n_eff);

    assign mem_we    = accept;
    assign mem_waddr = {bank_reg, held_reg[IW-1:0]};
    assign mem_wdata = sample_v;
    assign desc_push = complete;
    assign desc_data = {pend_reg | last_of_image, bank_reg, held_inc, total_add, sq_add};

    always_comb
    begin
        held_next  = held_reg;
        total_next = total_reg;
        sq_next    = sq_reg;
        pend_next  = pend_reg;
        bank_next  = bank_reg;
        if (complete)
        begin
            held_next  = '0;
            total_next = '0;
            sq_next    = '0;
            pend_next  = 1'b0;
            bank_next  = !bank_reg;
        end
        else if (accept)
        begin
            held_next  = held_inc;
            total_next = total_add;
            sq_next    = sq_add;
            pend_next  = pend_reg | last_of_image;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            total_reg <= '0;
            sq_reg    <= '0;
            pend_reg  <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            total_reg <= total_next;
            sq_reg    <= sq_next;
            pend_reg  <= pend_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== hw/rtl/mkss_back.sv =====
// Back end: sample store, threshold set-up, radix median select, clipping pass,
// serial divide and result register. Depends on mkss_pkg and the macro header.
`include "median_kappa_sigma_stacker_top_macros.svh"
module mkss_back #(
    parameter int MAX_FRAMES  = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int CW     = $clog2(MAX_FRAMES + 1),
    localparam int IW     = $clog2(MAX_FRAMES),
    localparam int AW     = IW + 1,
    localparam int TW     = SAMPLE_BITS + CW,
    localparam int QW     = 2 * SAMPLE_BITS + CW,
    localparam int DESC_W = 2 + CW + TW + QW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mem_we,
    input  logic [AW-1:0]               mem_waddr,
    input  logic [SAMPLE_BITS-1:0]      mem_wdata,
    input  mkss_pkg::q_status_t         q_status,
    input  logic [DESC_W-1:0]           q_data,
    output logic                        q_pop,
    input  logic [mkss_pkg::KAPPA_W-1:0] kappa,
    output logic                        busy,
    output logic                        empty,
    input  logic                        pop,
    output logic [15:0]                 stacked_value,
    output logic                        image_done
);
    import mkss_pkg::*;

    localparam int SB      = SAMPLE_BITS;
    localparam int BW      = $clog2(SB);
    localparam int SPW     = QW + CW;
    localparam int KSW     = 2 * KAPPA_W;
    localparam int K2W     = KSW + CW;
    localparam int HW      = (SPW + 1) / 2;
    localparam int RW      = K2W + SPW;
    localparam int DW      = SB + CW;
    localparam int DCW     = $clog2(TW + 1);
    localparam int MDEPTH  = 2 * (2 ** IW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_MED, ST_CLIP, ST_DIV, ST_DONE
    } state_t;

    logic [SB-1:0] mem [MDEPTH];
    logic [SB-1:0] mem_q_reg;

    state_t        state_reg, state_next;
    logic          done_reg, done_next;
    logic          bank_reg, bank_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] total_reg, total_next;
    logic [QW-1:0] sumsq_reg, sumsq_next;

    logic [SPW-1:0] prod_reg, prod_next, tsq_reg, tsq_next, spread_reg, spread_next;
    logic [KSW-1:0] ksq_reg, ksq_next;
    logic [K2W-1:0] k2n_reg, k2n_next;
    logic [K2W+HW-1:0]     plo_reg, plo_next;
    logic [K2W+SPW-HW-1:0] phi_reg, phi_next;
    logic [RW-1:0]  rhs_reg, rhs_next;

    logic [CW-1:0] rd_reg, rd_next;
    logic          rv_reg, rv_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [SB-1:0] prefix_reg, prefix_next;
    logic [CW-1:0] rank_reg, rank_next, count_reg, count_next;

    logic [3:0]    cv_reg, cv_next;
    logic [DW-1:0] nv_reg, d_reg;
    logic [2*DW-1:0] dsq_reg;
    logic [2*DW+CW-1:0] base_reg;
    logic [SB-1:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic [TW-1:0] acc_reg, acc_next;

    logic [CW:0]    rem_reg, rem_next, rem_sh;
    logic [TW-1:0]  quo_reg, quo_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;

    logic          out_valid_reg, out_valid_next;
    logic [15:0]   out_value_reg, out_value_next;
    logic          out_done_reg, out_done_next;

    logic          issue_en, match;
    logic [SB-1:0] above;
    logic [RW-1:0] lhs;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[{bank_reg, rd_reg[IW-1:0]}];
    end

    // clipping datapath, one stage per multiply or subtract
    always_ff @(posedge clk)
    begin
        nv_reg   <= DW'(cnt_reg) * DW'(mem_q_reg);
        v1_reg   <= mem_q_reg;
        d_reg    <= (nv_reg >= DW'(total_reg)) ? nv_reg - DW'(total_reg)
                                               : DW'(total_reg) - nv_reg;
        v2_reg   <= v1_reg;
        dsq_reg  <= (2 * DW)'(d_reg) * (2 * DW)'(d_reg);
        v3_reg   <= v2_reg;
        base_reg <= (2 * DW + CW)'(dsq_reg) * (2 * DW + CW)'(cnt_reg - 1'b1);
        v4_reg   <= v3_reg;
    end

    assign issue_en = (rd_reg < cnt_reg);
    assign above    = ({SB{1'b1}} << bit_reg) << 1;
    assign match    = (((mem_q_reg ^ prefix_reg) & above) == '0) && !mem_q_reg[bit_reg];
    assign lhs      = RW'({base_reg, {FRAC{1'b0}}});
    assign rem_sh   = {rem_reg[CW-1:0], quo_reg[TW-1]};
    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        bank_next      = bank_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        sumsq_next     = sumsq_reg;
        prod_next      = prod_reg;
        tsq_next       = tsq_reg;
        ksq_next       = ksq_reg;
        spread_next    = spread_reg;
        k2n_next       = k2n_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        rhs_next       = rhs_reg;
        rd_next        = rd_reg;
        rv_next        = 1'b0;
        bit_next       = bit_reg;
        prefix_next    = prefix_reg;
        rank_next      = rank_reg;
        count_next     = count_reg;
        cv_next        = {cv_reg[2:0], rv_reg && (state_reg == ST_CLIP)};
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_done_next  = out_done_reg;

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    {done_next, bank_next, cnt_next, total_next, sumsq_next} = q_data;
                    state_next = ST_P0;
                end
            end
            ST_P0:
            begin
                prod_next  = SPW'(cnt_reg) * SPW'(sumsq_reg);
                tsq_next   = SPW'(total_reg) * SPW'(total_reg);
                ksq_next   = KSW'(kappa) * KSW'(kappa);
                state_next = ST_P1;
            end
            ST_P1:
            begin
                spread_next = prod_reg - tsq_reg;
                k2n_next    = K2W'(ksq_reg) * K2W'(cnt_reg);
                state_next  = ST_P2;
            end
            ST_P2:
            begin
                plo_next   = (K2W + HW)'(k2n_reg) * (K2W + HW)'(spread_reg[HW-1:0]);
                state_next = ST_P3;
            end
            ST_P3:
            begin
                phi_next   = (K2W + SPW - HW)'(k2n_reg)
                           * (K2W + SPW - HW)'(spread_reg[SPW-1:HW]);
                state_next = ST_P4;
            end
            ST_P4:
            begin
                rhs_next    = RW'(plo_reg) + (RW'(phi_reg) << HW);
                bit_next    = BW'(SB - 1);
                prefix_next = '0;
                rank_next   = cnt_reg >> 1;
                count_next  = '0;
                rd_next     = '0;
                state_next  = ST_MED;
            end
            ST_MED:
            begin
                if (issue_en)
                begin
                    rd_next = rd_reg + 1'b1;
                    rv_next = 1'b1;
                end
                if (rv_reg && match)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (!issue_en && !rv_reg)
                begin
                    // rank at or past the count of zeros of this bit sets the bit in the prefix
                    if (rank_reg >= count_reg)
                    begin
                        prefix_next = prefix_reg | (SB'(1) << bit_reg);
                        rank_next   = rank_reg - count_reg;
                    end
                    count_next = '0;
                    rd_next    = '0;
                    if (bit_reg == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_CLIP;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                    end
                end
            end
            ST_CLIP:
            begin
                if (issue_en)
                begin
                    rd_next = rd_reg + 1'b1;
                    rv_next = 1'b1;
                end
                if (cv_reg[3])
                begin
                    acc_next = acc_reg + TW'((lhs <= rhs_reg) ? v4_reg : prefix_reg);
                end
                if (!issue_en && !rv_reg && (cv_reg == '0))
                begin
                    rem_next   = '0;
                    quo_next   = acc_reg;
                    dcnt_next  = DCW'(TW);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= (CW + 1)'(cnt_reg))
                begin
                    rem_next = rem_sh - (CW + 1)'(cnt_reg);
                    quo_next = {quo_reg[TW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[TW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = 16'(quo_reg[SB-1:0]);
                    out_done_next  = done_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rv_reg        <= 1'b0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
            rd_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rv_reg        <= rv_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
            rd_reg        <= rd_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        done_reg      <= done_next;
        bank_reg      <= bank_next;
        total_reg     <= total_next;
        sumsq_reg     <= sumsq_next;
        prod_reg      <= prod_next;
        tsq_reg       <= tsq_next;
        ksq_reg       <= ksq_next;
        spread_reg    <= spread_next;
        k2n_reg       <= k2n_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        rhs_reg       <= rhs_next;
        bit_reg       <= bit_next;
        prefix_reg    <= prefix_next;
        rank_reg      <= rank_next;
        count_reg     <= count_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dcnt_reg      <= dcnt_next;
        out_value_reg <= out_value_next;
        out_done_reg  <= out_done_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign empty         = !out_valid_reg;
    assign stacked_value = out_value_reg;
    assign image_done    = out_done_reg;

    `MKSS_ASSERT(a_cnt_range, (state_reg == ST_IDLE) || ((cnt_reg >= CW'(2)) && (cnt_reg <= CW'(MAX_FRAMES))))
    `MKSS_ASSERT(a_rank_in_pixel, (state_reg != ST_CLIP) || (rank_reg < cnt_reg))
    `MKSS_ASSERT_NEXT(a_result_held, out_valid_reg && !pop, out_valid_reg && $stable(out_value_reg))
    `MKSS_ASSERT_NEXT(a_pop_only_idle, q_pop, state_reg == ST_P0)

endmodule

// ===== hw/rtl/median_kappa_sigma_stacker_top.sv =====
// Median kappa-sigma stacker, top level: configuration registers and wiring of
// front end, descriptor queue and back end. Depends on mkss_pkg and its modules.
//
// Samples arrive pixel-major, frame_count words per pixel; the front end takes one
// word per cycle while full is low, into one of two sample banks, so a pixel can
// load while the previous one is processed. The back end walks the stored pixel once
// per median bit and once more for the clipping pass, then runs a bit-serial divide.
// The median radix passes over the single store read port dominate the time per
// pixel. Results wait in an output register while the front keeps loading; full
// rises only when both banks are taken.
module median_kappa_sigma_stacker_top #(
    parameter int MAX_FRAMES  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [15:0]                     sample,
    input  logic                            last_of_image,
    output logic                            empty,
    input  logic                            pop,
    output logic [15:0]                     stacked_value,
    output logic                            image_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mkss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mkss_pkg::*;

    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int IW     = $clog2(MAX_FRAMES);
    localparam int AW     = IW + 1;
    localparam int TW     = SAMPLE_BITS + CW;
    localparam int QW     = 2 * SAMPLE_BITS + CW;
    localparam int DESC_W = 2 + CW + TW + QW;
    localparam int EW     = ((CW > 7) ? CW : 7) + 1;

    logic [6:0]          fc_reg;
    logic [KAPPA_W-1:0]  kappa_reg;
    logic [EW-1:0]       fc_ext;
    logic [CW-1:0]       n_eff;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic                   desc_push, q_pop, back_busy;
    logic [DESC_W-1:0]      desc_data, q_data;
    q_status_t              q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg    <= FRAME_COUNT_RST;
            kappa_reg <= KAPPA_Q_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_COUNT: fc_reg    <= cfg_data[6:0];
                CFG_KAPPA_Q:     kappa_reg <= cfg_data[KAPPA_W-1:0];
                default:         ;
            endcase
        end
    end

    // frame count saturated to 2..MAX_FRAMES
    assign fc_ext = EW'(fc_reg);
    always_comb
    begin
        if (fc_ext < EW'(2))
        begin
            n_eff = CW'(2);
        end
        else if (fc_ext > EW'(MAX_FRAMES))
        begin
            n_eff = CW'(MAX_FRAMES);
        end
        else
        begin
            n_eff = fc_ext[CW-1:0];
        end
    end

    mkss_front #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .sample_v      (sample[SAMPLE_BITS-1:0]),
        .last_of_image (last_of_image),
        .n_eff         (n_eff),
        .q_status      (q_status),
        .back_busy     (back_busy),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .desc_push     (desc_push),
        .desc_data     (desc_data)
    );

    mkss_desc_q #(
        .WIDTH (DESC_W)
    ) u_desc_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_push),
        .wr_data (desc_data),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    mkss_back #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .q_status      (q_status),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .kappa         (kappa_reg),
        .busy          (back_busy),
        .empty         (empty),
        .pop           (pop),
        .stacked_value (stacked_value),
        .image_done    (image_done)
    );

endmodule
